// ===== rtl/core/gsac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gsac_pkg;

	// sizes fixed by the item formats
	localparam int EXP_TABLE_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH = 2;
	localparam int DELTA_W = 23;
	localparam int COV_W = 32;
	localparam int CH_W = 16;
	localparam int EPS_W = 24;
	localparam int FLOOR_W = 16;
	localparam int TRANS_W = 17;
	localparam int QUO_W = 21;
	localparam int S_DATA_W = 232;
	localparam int M_DATA_W = 48;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DET_EPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_T_FLOOR = 1'b1;

	// one splat as it travels through the queue
	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic signed [COV_W-1:0]   cov_xx;
		logic signed [COV_W-1:0]   cov_xy;
		logic signed [COV_W-1:0]   cov_yy;
		logic [CH_W-1:0]           opacity;
		logic [CH_W-1:0]           red;
		logic [CH_W-1:0]           green;
		logic [CH_W-1:0]           blue;
		logic                      last;
	} splat_t;

	localparam int SPLAT_W = $bits(splat_t);

	// bitwise long division, elaboration only
	function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		int b;
		q = 0;
		r = 0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16*i/depth) in Q.16: series for exp(-i/(2 depth)) then five squarings
	function automatic longint unsigned exp_entry(int unsigned i, int unsigned depth);
		longint unsigned y;
		longint unsigned term;
		longint unsigned s;
		longint sum;
		int k;
		y = cdiv(longint'(i) << 29, longint'(depth));
		term = 64'd1 << 30;
		sum = longint'(term);
		for (k = 1; k <= 16; k++) begin
			term = cdiv((term * y) >> 30, longint'(k));
			if ((k & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		s = (sum < 0) ? 64'd0 : longint'(sum);
		for (k = 0; k < 5; k++) s = (s * s) >> 30;
		return (s * 64'd65536 + (64'd1 << 29)) >> 30;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gsac_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gsac_fifo import gsac_pkg::*; #(
	parameter int WIDTH = SPLAT_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PW'(wr_ptr_q + 1'b1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PW'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop) count_q <= CW'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= CW'(count_q - 1'b1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count past depth");

endmodule
`default_nettype wire

// ===== rtl/core/gsac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gsac_front import gsac_pkg::*; (
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,
	input  wire logic                s_axis_tlast,
	input  wire logic                q_full,
	output logic                     q_push,
	output splat_t                   q_data
);
	logic [11:0] pixel_x, pixel_y;
	logic signed [20:0] center_x, center_y;
	logic signed [DELTA_W-1:0] dx, dy;

	// unpack the stream word
	assign pixel_x = s_axis_tdata[11:0];
	assign pixel_y = s_axis_tdata[23:12];
	assign center_x = $signed(s_axis_tdata[44:24]);
	assign center_y = $signed(s_axis_tdata[65:45]);

	// offsets from splat centre to pixel, Q.8
	assign dx = $signed({1'b0, pixel_x, 8'b0}) - center_x;
	assign dy = $signed({1'b0, pixel_y, 8'b0}) - center_y;

	always_comb begin
		q_data.dx = dx;
		q_data.dy = dy;
		q_data.cov_xx = $signed(s_axis_tdata[97:66]);
		q_data.cov_xy = $signed(s_axis_tdata[129:98]);
		q_data.cov_yy = $signed(s_axis_tdata[161:130]);
		q_data.opacity = s_axis_tdata[177:162];
		q_data.red = s_axis_tdata[193:178];
		q_data.green = s_axis_tdata[209:194];
		q_data.blue = s_axis_tdata[225:210];
		q_data.last = s_axis_tlast;
	end

	assign s_axis_tready = !q_full;
	assign q_push = s_axis_tvalid && !q_full;

endmodule
`default_nettype wire

// ===== rtl/core/gsac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gsac_back import gsac_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [EPS_W-1:0]   det_eps,
	input  wire logic [FLOOR_W-1:0] t_floor,
	input  wire logic               q_empty,
	input  wire splat_t             q_data,
	output logic                    q_pop,
	output logic                    m_valid,
	input  wire logic               m_ready,
	output logic [CH_W-1:0]         pixel_red,
	output logic [CH_W-1:0]         pixel_green,
	output logic [CH_W-1:0]         pixel_blue,
	output logic                    ended_early
);
	localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam logic [IW-1:0] DEPTH_V = IW'(EXP_TABLE_DEPTH);
	localparam logic [TRANS_W-1:0] T_ONE = TRANS_W'(65536);
	localparam logic [4:0] DIV_STEPS = 5'(QUO_W);

	// exp table, forced non-increasing
	typedef logic [TRANS_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		longint unsigned e;
		longint unsigned prev;
		int unsigned i;
		prev = 0;
		for (i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			e = exp_entry(i, EXP_TABLE_DEPTH);
			if (i > 0 && e > prev) e = prev;
			t[i] = TRANS_W'(e);
			prev = e;
		end
		return t;
	endfunction
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL = 4'd1;
	localparam logic [3:0] ST_DIFF = 4'd2;
	localparam logic [3:0] ST_PART = 4'd3;
	localparam logic [3:0] ST_SUM = 4'd4;
	localparam logic [3:0] ST_ABS = 4'd5;
	localparam logic [3:0] ST_CHECK = 4'd6;
	localparam logic [3:0] ST_DIV = 4'd7;
	localparam logic [3:0] ST_IDX = 4'd8;
	localparam logic [3:0] ST_LOOK = 4'd9;
	localparam logic [3:0] ST_INTERP = 4'd10;
	localparam logic [3:0] ST_ALPHA = 4'd11;
	localparam logic [3:0] ST_WEIGHT = 4'd12;
	localparam logic [3:0] ST_BLEND = 4'd13;
	localparam logic [3:0] ST_FIN = 4'd14;

	logic [3:0] state_q;
	splat_t item_q;

	// pixel state
	logic [TRANS_W-1:0] trans_q;
	logic [CH_W-1:0] acc_r_q, acc_g_q, acc_b_q;
	logic term_q;

	// datapath registers
	logic signed [63:0] p_xxyy_q, p_xyxy_q;
	logic signed [54:0] a_q, b_q, c_q;
	logic signed [64:0] det_q;
	logic signed [56:0] u_q;
	logic signed [54:0] v_q;
	logic signed [50:0] pu_hi_q;
	logic signed [52:0] pu_lo_q;
	logic signed [48:0] pv_hi_q;
	logic signed [52:0] pv_lo_q;
	logic [63:0] adet_q;
	logic signed [81:0] q_q;
	logic [80:0] qa_q;
	logic dflag_q, qzero_q, qneg_q;
	logic [63:0] rem_q;
	logic [QUO_W-1:0] quo_q, nbits_q;
	logic [4:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic [QUO_W-1:0] frac_q;
	logic [TRANS_W-1:0] e_lo_q, e_diff_q, e_q;
	logic [CH_W-1:0] alpha_q;
	logic [32:0] ta_q;

	// output register
	logic m_valid_q;
	logic [CH_W-1:0] out_r_q, out_g_q, out_b_q;
	logic out_e_q;

	// combinational products and sums
	logic signed [63:0] p_xxyy_d, p_xyxy_d;
	logic signed [54:0] a_d, b_d, c_d;
	logic signed [64:0] det_d, det_neg_d;
	logic signed [56:0] u_d;
	logic signed [27:0] u_hi;
	logic signed [29:0] u_lo;
	logic signed [25:0] v_hi;
	logic signed [29:0] v_lo;
	logic signed [DELTA_W-1:0] dx_s, dy_s;
	logic signed [50:0] pu_hi_d;
	logic signed [52:0] pu_lo_d;
	logic signed [48:0] pv_hi_d;
	logic signed [52:0] pv_lo_d;
	logic signed [81:0] q_d, q_neg_d;
	logic [80:0] lim_d;
	logic [64:0] rem2_d;
	logic [QUO_W+IW-1:0] t_d;
	logic [37:0] interp_d;
	logic [32:0] alpha_d;
	logic [48:0] cr_d, cg_d, cb_d;
	logic [17:0] sr_d, sg_d, sb_d;
	logic [33:0] tn_d;
	logic term_now, out_free, emit;

	assign dx_s = item_q.dx;
	assign dy_s = item_q.dy;

	// determinant and quadratic form products
	assign p_xxyy_d = item_q.cov_xx * item_q.cov_yy;
	assign p_xyxy_d = item_q.cov_xy * item_q.cov_xy;
	assign a_d = item_q.cov_yy * dx_s;
	assign b_d = item_q.cov_xy * dy_s;
	assign c_d = item_q.cov_xx * dy_s;
	assign det_d = p_xxyy_q - p_xyxy_q;
	assign u_d = 57'(a_q) - (57'(b_q) <<< 1);
	assign u_hi = $signed(u_q[56:29]);
	assign u_lo = $signed({1'b0, u_q[28:0]});
	assign v_hi = $signed(v_q[54:29]);
	assign v_lo = $signed({1'b0, v_q[28:0]});
	assign pu_hi_d = dx_s * u_hi;
	assign pu_lo_d = dx_s * u_lo;
	assign pv_hi_d = dy_s * v_hi;
	assign pv_lo_d = dy_s * v_lo;
	assign det_neg_d = -det_q;
	assign q_d = (82'(pu_hi_q) <<< 29) + 82'(pu_lo_q) + (82'(pv_hi_q) <<< 29) + 82'(pv_lo_q);
	assign q_neg_d = -q_q;
	assign lim_d = {8'b0, adet_q, 9'b0};

	// one quotient bit per step
	assign rem2_d = {rem_q, nbits_q[QUO_W-1]};

	// table position and interpolation
	assign t_d = quo_q * DEPTH_V;
	assign interp_d = e_diff_q * frac_q;
	assign alpha_d = item_q.opacity * e_q + 33'd32768;

	// blending
	assign cr_d = item_q.red * ta_q + 49'h0_8000_0000;
	assign cg_d = item_q.green * ta_q + 49'h0_8000_0000;
	assign cb_d = item_q.blue * ta_q + 49'h0_8000_0000;
	assign sr_d = 18'(acc_r_q) + 18'(cr_d[48:32]);
	assign sg_d = 18'(acc_g_q) + 18'(cg_d[48:32]);
	assign sb_d = 18'(acc_b_q) + 18'(cb_d[48:32]);
	assign tn_d = trans_q * (T_ONE - TRANS_W'(alpha_q)) + 34'd32768;

	assign term_now = term_q || (trans_q < TRANS_W'(t_floor));
	assign out_free = !m_valid_q || m_ready;
	assign emit = (state_q == ST_FIN) && item_q.last && out_free;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) item_q <= q_data;
			end
			ST_MUL: begin
				p_xxyy_q <= p_xxyy_d;
				p_xyxy_q <= p_xyxy_d;
				a_q <= a_d;
				b_q <= b_d;
				c_q <= c_d;
			end
			ST_DIFF: begin
				det_q <= det_d;
				u_q <= u_d;
				v_q <= c_q;
			end
			ST_PART: begin
				pu_hi_q <= pu_hi_d;
				pu_lo_q <= pu_lo_d;
				pv_hi_q <= pv_hi_d;
				pv_lo_q <= pv_lo_d;
				adet_q <= det_q[64] ? det_neg_d[63:0] : det_q[63:0];
			end
			ST_SUM: begin
				q_q <= q_d;
				dflag_q <= (det_q == '0) || (adet_q < 64'(det_eps));
			end
			ST_ABS: begin
				qa_q <= q_q[81] ? q_neg_d[80:0] : q_q[80:0];
				qzero_q <= (q_q == '0);
				qneg_q <= q_q[81];
			end
			ST_CHECK: begin
				alpha_q <= '0;
				e_q <= EXP_TAB[0];
				rem_q <= qa_q[72:9];
				nbits_q <= {qa_q[8:0], 12'b0};
				quo_q <= '0;
				cnt_q <= DIV_STEPS;
			end
			ST_DIV: begin
				if (rem2_d >= {1'b0, adet_q}) begin
					rem_q <= 64'(rem2_d - {1'b0, adet_q});
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2_d[63:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				nbits_q <= {nbits_q[QUO_W-2:0], 1'b0};
				cnt_q <= 5'(cnt_q - 1'b1);
			end
			ST_IDX: begin
				idx_q <= t_d[QUO_W+IW-1:QUO_W];
				frac_q <= t_d[QUO_W-1:0];
			end
			ST_LOOK: begin
				e_lo_q <= EXP_TAB[idx_q];
				e_diff_q <= EXP_TAB[idx_q] - EXP_TAB[IW'(idx_q + 1'b1)];
			end
			ST_INTERP: begin
				e_q <= e_lo_q - interp_d[37:21];
			end
			ST_ALPHA: begin
				alpha_q <= alpha_d[31:16];
			end
			ST_WEIGHT: begin
				ta_q <= trans_q * alpha_q;
			end
			ST_BLEND, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and pixel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trans_q <= T_ONE;
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
			term_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) state_q <= term_q ? ST_FIN : ST_MUL;
				end
				ST_MUL: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_PART;
				ST_PART: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_ABS;
				ST_ABS: state_q <= ST_CHECK;
				ST_CHECK: begin
					// flat determinant, wrong sign or power past the table all give zero alpha
					priority if (dflag_q) state_q <= ST_WEIGHT;
					else if (qzero_q) state_q <= ST_ALPHA;
					else if (qneg_q != det_q[64]) state_q <= ST_WEIGHT;
					else if (qa_q >= lim_d) state_q <= ST_WEIGHT;
					else state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 5'd1) state_q <= ST_IDX;
				end
				ST_IDX: state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_ALPHA;
				ST_ALPHA: state_q <= ST_WEIGHT;
				ST_WEIGHT: state_q <= ST_BLEND;
				ST_BLEND: begin
					acc_r_q <= sr_d[17:16] != 2'b0 ? '1 : sr_d[15:0];
					acc_g_q <= sg_d[17:16] != 2'b0 ? '1 : sg_d[15:0];
					acc_b_q <= sb_d[17:16] != 2'b0 ? '1 : sb_d[15:0];
					trans_q <= tn_d[32:16];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!item_q.last) begin
						term_q <= term_now;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						trans_q <= T_ONE;
						acc_r_q <= '0;
						acc_g_q <= '0;
						acc_b_q <= '0;
						term_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						term_q <= term_now;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_r_q <= acc_r_q;
			out_g_q <= acc_g_q;
			out_b_q <= acc_b_q;
			out_e_q <= term_now;
		end
	end

	assign m_valid = m_valid_q;
	assign pixel_red = out_r_q;
	assign pixel_green = out_g_q;
	assign pixel_blue = out_b_q;
	assign ended_early = out_e_q;

	a_trans_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trans_q <= T_ONE) else $error("transmittance above one");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < adet_q) else $error("divider remainder out of range");

	a_pixel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> trans_q == T_ONE && acc_r_q == '0 && acc_g_q == '0 && acc_b_q == '0 && !term_q)
		else $error("pixel state not cleared after result");

endmodule
`default_nettype wire

// ===== rtl/core/gaussian_splat_alpha_compositor_top.sv =====
// a splat that needs the power division runs every sequencer state; forced zero alpha and a
// zero quadratic form skip the division and lookup, and a terminated pixel goes idle to finish
// one splat at a time; a pixel's last splat holds until the result register is free
// a two-item queue sits between the input side and the sequencer
// reset: asynchronous, clears the pixel state to full transmittance and zero colour,
// det_epsilon to 17 and transmittance_floor to 7
`timescale 1ns / 1ps
`default_nettype none
module gaussian_splat_alpha_compositor_top import gsac_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// pixel_x, pixel_y, center_x, center_y, cov_xx, cov_xy, cov_yy, opacity, red, green, blue
	input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// pixel_red, pixel_green, pixel_blue
	output logic [M_DATA_W-1:0]        m_axis_tdata,
	// ended_early
	output logic                       m_axis_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic [EPS_W-1:0] det_eps_q;
	logic [FLOOR_W-1:0] t_floor_q;
	logic q_push, q_full, q_pop, q_empty;
	splat_t push_item, pop_item;
	logic [SPLAT_W-1:0] pop_bits;
	logic [CH_W-1:0] pix_r, pix_g, pix_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q <= EPS_W'(17);
			t_floor_q <= FLOOR_W'(7);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DET_EPS: det_eps_q <= cfg_data[EPS_W-1:0];
				REG_T_FLOOR: t_floor_q <= cfg_data[FLOOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gsac_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(push_item)
	);

	gsac_fifo #(
		.WIDTH(SPLAT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(push_item),
		.full(q_full),
		.pop(q_pop),
		.pop_data(pop_bits),
		.empty(q_empty)
	);

	assign pop_item = splat_t'(pop_bits);

	gsac_back #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.det_eps(det_eps_q),
		.t_floor(t_floor_q),
		.q_empty(q_empty),
		.q_data(pop_item),
		.q_pop(q_pop),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.pixel_red(pix_r),
		.pixel_green(pix_g),
		.pixel_blue(pix_b),
		.ended_early(m_axis_tuser)
	);

	assign m_axis_tdata = {pix_b, pix_g, pix_r};

endmodule
`default_nettype wire
